@@ design/sleep_delta_queue_top_macros.svh @@
// Assertion macros shared by the sleep delta queue modules.
`ifndef SLEEP_DELTA_QUEUE_TOP_MACROS_SVH
`define SLEEP_DELTA_QUEUE_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is applied.
`define SDQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication, disabled while reset is applied.
`define SDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define SDQ_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define SDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ design/sdq_pkg.sv @@
// Shared types and constants for the sleep delta queue.
`timescale 1ns / 1ps
`default_nettype none

package sdq_pkg;

  // Default sizes of the entry store and its fields.
  localparam int DEPTH_DEF      = 16;
  localparam int ID_WIDTH_DEF   = 8;
  localparam int TIME_WIDTH_DEF = 16;

  // Width of the command selector.
  localparam int CMD_W = 2;

  // Command codes carried on the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_SLEEP   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  // Logical index of the store read issued this cycle.
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_ONE,
    RD_IDX,
    RD_IDX_INC,
    RD_CNT_M1,
    RD_SH_M2
  } rd_sel_t;

  // Store write issued this cycle.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT,
    WR_FIX,
    WR_INS,
    WR_HEAD
  } wr_sel_t;

  // Source of the id in a loaded result.
  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_CUR,
    OUT_RD
  } out_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     walk_step;
    logic     walk_stop;
    logic     sh_dec;
    logic     idx_inc;
    logic     count_inc;
    logic     drop;
    logic     clear;
    logic     cur_load;
    logic     out_load;
    logic     out_woken;
    logic     out_status;
    logic     out_last;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    out_src_t out_src;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_end;
    logic walk_le;
    logic shift_more;
    logic head_dec_zero;
    logic next_nz;
    logic rel_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/sdq_datapath.sv @@
// Datapath of the sleep delta queue: circular entry store, pointers and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "sleep_delta_queue_top_macros.svh"

module sdq_datapath #(
  parameter int DEPTH      = sdq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH   = sdq_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH = sdq_pkg::TIME_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  sdq_pkg::dp_cmd_t       cmd,
  output sdq_pkg::dp_stat_t      stat,
  input  wire [ID_WIDTH-1:0]     in_id,
  input  wire [TIME_WIDTH-1:0]   in_ticks,
  output logic                   out_woken,
  output logic [ID_WIDTH-1:0]    out_id,
  output logic                   out_status,
  output logic                   out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_WIDTH + TIME_WIDTH;

  // Physical slot of a logical position counted from the head.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Entry store and its registered read data.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;

  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r;
  logic [CW-1:0]         sh_r;
  logic [TIME_WIDTH-1:0] rem_r;
  logic [ID_WIDTH-1:0]   id_r;
  logic [ID_WIDTH-1:0]   stop_id_r;
  logic [TIME_WIDTH-1:0] stop_dl_r;
  logic [ID_WIDTH-1:0]   cur_id_r;

  logic [ID_WIDTH-1:0]   rd_id;
  logic [TIME_WIDTH-1:0] rd_dl;
  logic [CW-1:0]         rd_idx;
  logic [CW-1:0]         wr_idx;
  logic [EW-1:0]         wr_data;
  logic                  wr_en;
  logic [ID_WIDTH-1:0]   out_id_sel;

  assign rd_id = rdata_r[EW-1:TIME_WIDTH];
  assign rd_dl = rdata_r[TIME_WIDTH-1:0];

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      sdq_pkg::RD_ZERO:    rd_idx = '0;
      sdq_pkg::RD_ONE:     rd_idx = CW'(1);
      sdq_pkg::RD_IDX:     rd_idx = idx_r;
      sdq_pkg::RD_IDX_INC: rd_idx = idx_r + CW'(1);
      sdq_pkg::RD_CNT_M1:  rd_idx = count_r - CW'(1);
      sdq_pkg::RD_SH_M2:   rd_idx = sh_r - CW'(2);
      default:             rd_idx = '0;
    endcase
  end

  // Write address and data selection.
  always_comb begin
    wr_en   = 1'b1;
    wr_idx  = '0;
    wr_data = rdata_r;
    unique case (cmd.wr_sel)
      sdq_pkg::WR_NONE: begin
        wr_en = 1'b0;
      end
      sdq_pkg::WR_SHIFT: begin
        wr_idx = sh_r;
      end
      sdq_pkg::WR_FIX: begin
        wr_idx  = idx_r + CW'(1);
        wr_data = {stop_id_r, stop_dl_r - rem_r};
      end
      sdq_pkg::WR_INS: begin
        wr_idx  = idx_r;
        wr_data = {id_r, rem_r};
      end
      sdq_pkg::WR_HEAD: begin
        wr_idx  = '0;
        wr_data = {rd_id, rd_dl - TIME_WIDTH'(1)};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wrap_add(head_r, wr_idx)] <= wr_data;
    end
    rdata_r <= mem[wrap_add(head_r, rd_idx)];
  end

  // Head pointer and fill count.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.drop) begin
      head_nxt  = wrap_add(head_r, CW'(1));
      count_nxt = count_r - CW'(1);
    end else if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Walk, shift and wake working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_r  <= in_id;
      rem_r <= in_ticks;
      idx_r <= '0;
    end else if (cmd.walk_step) begin
      rem_r <= rem_r - rd_dl;
      idx_r <= idx_r + CW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.walk_stop) begin
      stop_id_r <= rd_id;
      stop_dl_r <= rd_dl;
      sh_r      <= count_r;
    end else if (cmd.sh_dec) begin
      sh_r <= sh_r - CW'(1);
    end
    if (cmd.cur_load) begin
      cur_id_r <= rd_id;
    end
  end

  // Result register.
  always_comb begin
    unique case (cmd.out_src)
      sdq_pkg::OUT_ZERO: out_id_sel = '0;
      sdq_pkg::OUT_CUR:  out_id_sel = cur_id_r;
      sdq_pkg::OUT_RD:   out_id_sel = rd_id;
      default:           out_id_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_woken  <= cmd.out_woken;
      out_id     <= out_id_sel;
      out_status <= cmd.out_status;
      out_last   <= cmd.out_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.full          = (count_r == CW'(DEPTH));
    stat.empty         = (count_r == '0);
    stat.walk_end      = (idx_r == count_r);
    stat.walk_le       = (rd_dl <= rem_r);
    stat.shift_more    = ((CW+1)'(sh_r) >= (CW+1)'(idx_r) + (CW+1)'(2));
    stat.head_dec_zero = (rd_dl <= TIME_WIDTH'(1));
    stat.next_nz       = (rd_dl != '0);
    stat.rel_last      = ((CW+1)'(idx_r) + (CW+1)'(1) == (CW+1)'(count_r));
  end

  `SDQ_ASSERT_NOW(a_no_overfill, clk, rst_n, cmd.count_inc, count_r < CW'(DEPTH))
  `SDQ_ASSERT_NOW(a_drop_nonempty, clk, rst_n, cmd.drop, count_r != '0)

endmodule

`default_nettype wire

@@ design/sdq_ctrl.sv @@
// Controller of the sleep delta queue: command sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none

`include "sleep_delta_queue_top_macros.svh"

module sdq_ctrl (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire [sdq_pkg::CMD_W-1:0]   in_cmd,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output sdq_pkg::dp_cmd_t           dp_cmd,
  input  sdq_pkg::dp_stat_t          dp_stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STAT,
    SL_WALK,
    SL_SHIFT,
    SL_FIX,
    SL_INS,
    TK_HEAD,
    TK_NEXT,
    RL_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   stat_r, stat_nxt;
  logic   out_free;
  logic   tk_last;

  // The result register can take a beat when empty or being drained.
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign tk_last    = dp_stat.empty || dp_stat.next_nz;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    dp_cmd    = '0;
    unique case (state_r)
      ST_IDLE: begin
        dp_cmd.rd_sel = sdq_pkg::RD_ZERO;
        if (in_tvalid) begin
          dp_cmd.load_in = 1'b1;
          stat_nxt       = 1'b0;
          unique case (in_cmd)
            sdq_pkg::CMD_SLEEP: begin
              if (dp_stat.full) begin
                stat_nxt  = 1'b1;
                state_nxt = ST_STAT;
              end else begin
                state_nxt = SL_WALK;
              end
            end
            sdq_pkg::CMD_TICK: begin
              state_nxt = dp_stat.empty ? ST_STAT : TK_HEAD;
            end
            sdq_pkg::CMD_RELEASE: begin
              state_nxt = dp_stat.empty ? ST_STAT : RL_OUT;
            end
            default: begin
              state_nxt = ST_STAT;
            end
          endcase
        end
      end
      ST_STAT: begin
        if (out_free) begin
          dp_cmd.out_load   = 1'b1;
          dp_cmd.out_src    = sdq_pkg::OUT_ZERO;
          dp_cmd.out_status = stat_r;
          dp_cmd.out_last   = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      // Find the insertion point, one entry per cycle.
      SL_WALK: begin
        if (dp_stat.walk_end) begin
          state_nxt = SL_INS;
        end else if (dp_stat.walk_le) begin
          dp_cmd.walk_step = 1'b1;
          dp_cmd.rd_sel    = sdq_pkg::RD_IDX_INC;
        end else begin
          dp_cmd.walk_stop = 1'b1;
          dp_cmd.rd_sel    = sdq_pkg::RD_CNT_M1;
          state_nxt        = SL_SHIFT;
        end
      end
      // Move the tail up by one slot, from the end down.
      SL_SHIFT: begin
        if (dp_stat.shift_more) begin
          dp_cmd.wr_sel = sdq_pkg::WR_SHIFT;
          dp_cmd.sh_dec = 1'b1;
          dp_cmd.rd_sel = sdq_pkg::RD_SH_M2;
        end else begin
          state_nxt = SL_FIX;
        end
      end
      SL_FIX: begin
        dp_cmd.wr_sel = sdq_pkg::WR_FIX;
        state_nxt     = SL_INS;
      end
      SL_INS: begin
        dp_cmd.wr_sel    = sdq_pkg::WR_INS;
        dp_cmd.count_inc = 1'b1;
        state_nxt        = ST_STAT;
      end
      // Decrement the head, or start waking it.
      TK_HEAD: begin
        if (!dp_stat.head_dec_zero) begin
          dp_cmd.wr_sel = sdq_pkg::WR_HEAD;
          state_nxt     = ST_STAT;
        end else begin
          dp_cmd.cur_load = 1'b1;
          dp_cmd.drop     = 1'b1;
          dp_cmd.rd_sel   = sdq_pkg::RD_ONE;
          state_nxt       = TK_NEXT;
        end
      end
      // Emit the woken thread; the new head tells whether it is the last.
      TK_NEXT: begin
        if (out_free) begin
          dp_cmd.out_load  = 1'b1;
          dp_cmd.out_woken = 1'b1;
          dp_cmd.out_src   = sdq_pkg::OUT_CUR;
          dp_cmd.out_last  = tk_last;
          if (tk_last) begin
            state_nxt = ST_IDLE;
          end else begin
            dp_cmd.cur_load = 1'b1;
            dp_cmd.drop     = 1'b1;
            dp_cmd.rd_sel   = sdq_pkg::RD_ONE;
          end
        end else begin
          dp_cmd.rd_sel = sdq_pkg::RD_ZERO;
        end
      end
      // Stream every entry out in order.
      RL_OUT: begin
        if (out_free) begin
          dp_cmd.out_load  = 1'b1;
          dp_cmd.out_woken = 1'b1;
          dp_cmd.out_src   = sdq_pkg::OUT_RD;
          dp_cmd.out_last  = dp_stat.rel_last;
          if (dp_stat.rel_last) begin
            dp_cmd.clear = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            dp_cmd.idx_inc = 1'b1;
            dp_cmd.rd_sel  = sdq_pkg::RD_IDX_INC;
          end
        end else begin
          dp_cmd.rd_sel = sdq_pkg::RD_IDX;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid follows loads and drains.
  always_comb begin
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      stat_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      stat_r      <= stat_nxt;
    end
  end

  `SDQ_ASSERT_NOW(a_load_when_free, clk, rst_n, dp_cmd.out_load, !out_valid_r || out_tready)
  `SDQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

`default_nettype wire

@@ design/sleep_delta_queue_top.sv @@
// Top level of the sleep delta queue: stream ports, controller and datapath.
//
// Sleep queue for threads kept as a delta list in a circular entry store.
// Input channel (in_*): one beat per command. in_tuser carries the command
// (sleep, tick, release all); in_tdata carries thread id and sleep ticks.
// Output channel (out_*): one beat per woken thread, otherwise one status
// beat; out_tlast marks the final beat caused by a command.
// A sleep finds the insertion point and moves the tail one entry per cycle
// through the single read and write port of the store. A tick decrements the
// head delta or wakes the head and each following thread with a zero delta;
// a release all streams every entry out in order.
// One command is worked on at a time; in_tready is high only when idle.
// The last result may still wait in the output register while the next
// command is taken. When the receiver stalls, the block holds its result
// and waits without losing any beat.
// Reset empties the queue at once; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sleep_delta_queue_top #(
  parameter int DEPTH      = sdq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH   = sdq_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH = sdq_pkg::TIME_WIDTH_DEF,
  localparam int IN_W      = ((ID_WIDTH + TIME_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((ID_WIDTH + 1 + 7) / 8) * 8
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire [IN_W-1:0]             in_tdata,  // thread_id, sleep_ticks
  input  wire [sdq_pkg::CMD_W-1:0]   in_tuser,  // cmd
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [OUT_W-1:0]           out_tdata, // woken_id, status
  output logic                       out_tuser, // woken
  output logic                       out_tlast  // last
);

  sdq_pkg::dp_cmd_t    dp_cmd;
  sdq_pkg::dp_stat_t   dp_stat;
  logic [ID_WIDTH-1:0] res_id;
  logic                res_status;

  sdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  sdq_datapath #(
    .DEPTH      (DEPTH),
    .ID_WIDTH   (ID_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .in_id      (in_tdata[ID_WIDTH-1:0]),
    .in_ticks   (in_tdata[ID_WIDTH+TIME_WIDTH-1:ID_WIDTH]),
    .out_woken  (out_tuser),
    .out_id     (res_id),
    .out_status (res_status),
    .out_last   (out_tlast)
  );

  // Pack the result fields, lowest first, zero filled.
  assign out_tdata = OUT_W'({res_status, res_id});

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the sleep delta queue with stream stimulus and a wake-order predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int ID_W        = sdq_pkg::ID_WIDTH_DEF;
  localparam int TICK_W      = sdq_pkg::TIME_WIDTH_DEF;
  localparam int SLOTS       = sdq_pkg::DEPTH_DEF;
  localparam int IN_W        = ((ID_W + TICK_W + 7) / 8) * 8;
  localparam int OUT_W       = ((ID_W + 1 + 7) / 8) * 8;
  localparam int SETTLE      = SLOTS + 24;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;

  // The command encoding leaves this value unused; the block must still answer it.
  localparam logic [sdq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [sdq_pkg::CMD_W-1:0] cmd;
    logic [ID_W-1:0]           id;
    logic [TICK_W-1:0]         ticks;
  } command_t;

  typedef struct packed {
    logic            woken;
    logic [ID_W-1:0] woken_id;
    logic            status;
    logic            last;
  } wake_result_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] delta;
  } sleeper_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_W-1:0]           in_tdata = '0;
  logic [sdq_pkg::CMD_W-1:0] in_tuser = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_W-1:0]          out_tdata;
  logic                      out_tuser;
  logic                      out_tlast;

  command_t     command_backlog[$];
  command_t     offered_cmd;
  wake_result_t wake_results[$];
  sleeper_t     sleepers[$];

  int   idle_pct = 0;
  int   stall_pct = 0;
  int   errors = 0;
  logic hold_go = 1'b0;
  int   hold_count = 0;
  int   quiet_cycles;

  sleep_delta_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Free-running clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append one expected result beat.
  task automatic expect_beat(input logic woken, input logic [ID_W-1:0] id,
                             input logic status, input logic last);
    wake_result_t r;
    r.woken    = woken;
    r.woken_id = id;
    r.status   = status;
    r.last     = last;
    wake_results.push_back(r);
  endtask

  // Update the sleeping-thread list for one accepted command and queue the
  // result beats it must produce.
  task automatic apply_command(input command_t c);
    int                pos;
    int                woke;
    logic [TICK_W-1:0] rem;
    sleeper_t          s;
    unique case (c.cmd)
      sdq_pkg::CMD_SLEEP: begin
        if (sleepers.size() >= SLOTS) begin
          expect_beat(1'b0, '0, 1'b1, 1'b1);
        end else begin
          // Walk past every entry that wakes no later than the new thread.
          pos = 0;
          rem = c.ticks;
          while (pos < sleepers.size() && sleepers[pos].delta <= rem) begin
            rem = rem - sleepers[pos].delta;
            pos++;
          end
          if (pos < sleepers.size()) sleepers[pos].delta = sleepers[pos].delta - rem;
          s.id    = c.id;
          s.delta = rem;
          sleepers.insert(pos, s);
          expect_beat(1'b0, '0, 1'b0, 1'b1);
        end
      end
      sdq_pkg::CMD_TICK: begin
        woke = 0;
        if (sleepers.size() > 0 && sleepers[0].delta != 0)
          sleepers[0].delta = sleepers[0].delta - 1'b1;
        while (sleepers.size() > 0 && sleepers[0].delta == 0) begin
          s = sleepers.pop_front();
          expect_beat(1'b1, s.id, 1'b0, 1'b0);
          woke++;
        end
        if (woke == 0) expect_beat(1'b0, '0, 1'b0, 1'b1);
        else wake_results[wake_results.size() - 1].last = 1'b1;
      end
      sdq_pkg::CMD_RELEASE: begin
        if (sleepers.size() == 0) begin
          expect_beat(1'b0, '0, 1'b0, 1'b1);
        end else begin
          while (sleepers.size() > 0) begin
            s = sleepers.pop_front();
            expect_beat(1'b1, s.id, 1'b0, sleepers.size() == 0);
          end
        end
      end
      default: begin
        expect_beat(1'b0, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic queue_cmd(input logic [sdq_pkg::CMD_W-1:0] cmd,
                           input logic [ID_W-1:0] id,
                           input logic [TICK_W-1:0] ticks);
    command_t c;
    c.cmd   = cmd;
    c.id    = id;
    c.ticks = ticks;
    command_backlog.push_back(c);
  endtask

  // Mostly short sleeps so that ties and zero deltas are common.
  function automatic logic [TICK_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 50) return TICK_W'($urandom_range(3));
    if (r < 75) return TICK_W'($urandom_range(40));
    if (r < 90) return TICK_W'($urandom_range((1 << TICK_W) - 1));
    return {TICK_W{1'b1}} - TICK_W'($urandom_range(1));
  endfunction

  // Random traffic built from sleep bursts, tick bursts and occasional
  // release or unused commands.
  task automatic queue_random(input int count, input bit open_with_fill);
    int made;
    int len;
    int pick;
    int k;
    made = 0;
    while (made < count) begin
      pick = open_with_fill && made == 0 ? 0 : $urandom_range(99);
      if (pick < 25) begin
        len = open_with_fill && made == 0 ? SLOTS + 2 : $urandom_range(4, SLOTS + 2);
        for (k = 0; k < len; k++)
          queue_cmd(sdq_pkg::CMD_SLEEP, ID_W'($urandom), pick_ticks());
      end else if (pick < 55) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++)
          queue_cmd(sdq_pkg::CMD_TICK, ID_W'($urandom), TICK_W'($urandom));
      end else if (pick < 65) begin
        len = 1;
        queue_cmd(sdq_pkg::CMD_RELEASE, ID_W'($urandom), TICK_W'($urandom));
      end else if (pick < 70) begin
        len = 1;
        queue_cmd(CMD_UNUSED, ID_W'($urandom), TICK_W'($urandom));
      end else begin
        len = 1;
        if ($urandom_range(1)) queue_cmd(sdq_pkg::CMD_SLEEP, ID_W'($urandom), pick_ticks());
        else queue_cmd(sdq_pkg::CMD_TICK, ID_W'($urandom), TICK_W'($urandom));
      end
      made += len;
    end
  endtask

  // Wait until every command is taken and every result beat has arrived.
  task automatic drain();
    while (command_backlog.size() > 0 || in_tvalid || wake_results.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Driver: offer the next command when the current beat is taken or none is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) apply_command(offered_cmd);
      if (command_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
        offered_cmd = command_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_W'({offered_cmd.ticks, offered_cmd.id});
        in_tuser  <= offered_cmd.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once by the sequence below.
  always @(posedge clk) begin
    if (hold_go && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
  end

  // Receiver ready with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_go && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    wake_result_t got;
    wake_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.woken    = out_tuser;
      got.woken_id = out_tdata[ID_W-1:0];
      got.status   = out_tdata[ID_W];
      got.last     = out_tlast;
      if (wake_results.size() == 0) begin
        $display("%0t: unexpected beat woken=%0b id=%0d status=%0b last=%0b",
                 $realtime, got.woken, got.woken_id, got.status, got.last);
        errors++;
      end else begin
        want = wake_results.pop_front();
        if (got.woken !== want.woken || got.woken_id !== want.woken_id ||
            got.status !== want.status || got.last !== want.last) begin
          $display({"%0t: expected woken=%0b id=%0d status=%0b last=%0b, ",
                    "got woken=%0b id=%0d status=%0b last=%0b"},
                   $realtime, want.woken, want.woken_id, want.status, want.last,
                   got.woken, got.woken_id, got.status, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up when no beat moves on either side for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-queue cases, the unused command, ties, a zero sleep,
    // the longest sleep, ticks that wake one, two or nobody.
    queue_cmd(sdq_pkg::CMD_TICK, '0, '0);
    queue_cmd(sdq_pkg::CMD_RELEASE, '0, '0);
    queue_cmd(CMD_UNUSED, {ID_W{1'b1}}, {TICK_W{1'b1}});
    queue_cmd(sdq_pkg::CMD_SLEEP, 8'h11, 16'd2);
    queue_cmd(sdq_pkg::CMD_SLEEP, 8'h22, 16'd2);
    queue_cmd(sdq_pkg::CMD_SLEEP, 8'h33, 16'd0);
    queue_cmd(sdq_pkg::CMD_SLEEP, {ID_W{1'b1}}, {TICK_W{1'b1}});
    queue_cmd(sdq_pkg::CMD_SLEEP, '0, 16'd1);
    queue_cmd(sdq_pkg::CMD_TICK, '0, '0);
    queue_cmd(sdq_pkg::CMD_TICK, '0, '0);
    queue_cmd(sdq_pkg::CMD_TICK, '0, '0);
    queue_cmd(sdq_pkg::CMD_TICK, '0, '0);
    queue_cmd(sdq_pkg::CMD_RELEASE, '0, '0);
    drain();

    // Receiver holds off while the sender keeps pushing a full queue and more.
    hold_go = 1'b1;
    queue_random(24, 1'b1);
    drain();

    // Random traffic under each idling and stalling pattern.
    queue_random(40, 1'b1);
    drain();
    idle_pct  = 60;
    queue_random(40, 1'b0);
    drain();
    idle_pct  = 0;
    stall_pct = 60;
    queue_random(40, 1'b1);
    drain();
    idle_pct  = 28;
    stall_pct = 28;
    queue_random(40, 1'b0);
    drain();

    if (errors == 0 && wake_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sdq_pkg.sv
design/sdq_datapath.sv
design/sdq_ctrl.sv
design/sleep_delta_queue_top.sv
tb/tb_top.sv
